>>> hw/rtl/pdrv_pkg.sv
// Shared types, widths and constants of the PID position drive.
package pdrv_pkg;

	localparam int POS_W   = 16;
	localparam int ERR_W   = POS_W + 1;
	localparam int DLT_W   = POS_W + 2;
	localparam int MAG_W   = POS_W + 1;
	localparam int GAIN_W  = 32;
	localparam int TICK_W  = 16;
	localparam int FRAC_W  = 24;
	localparam int INTEG_W = 48;
	localparam int PROD_W  = GAIN_W + MAG_W;
	localparam int SUM_W   = PROD_W + 2;
	localparam int TOTAL_W = SUM_W + 1;
	localparam int RND_W   = TOTAL_W - FRAC_W;
	localparam int DRV_W   = 8;
	localparam int LIM_W   = 7;
	localparam int BAND_W  = 8;
	localparam int CNT_W   = 6;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int IDX_W   = ADDR_W - 2;

	localparam logic [INTEG_W-1:0] INTEG_LIM = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam logic signed [ERR_W-1:0] PREV_INIT = 17'sd10;

	localparam logic [IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
	localparam logic [IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
	localparam logic [IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_DRIVE   = 3'd3;
	localparam logic [IDX_W-1:0] REG_MAX_DRIVE   = 3'd4;
	localparam logic [IDX_W-1:0] REG_SETTLE_BAND = 3'd5;
	localparam logic [IDX_W-1:0] REG_TARGET_LOW  = 3'd6;
	localparam logic [IDX_W-1:0] REG_TARGET_HIGH = 3'd7;

	typedef struct packed {
		logic [GAIN_W-1:0]       prop_gain;
		logic [GAIN_W-1:0]       integ_gain;
		logic [GAIN_W-1:0]       deriv_gain;
		logic [LIM_W-1:0]        min_drive;
		logic [LIM_W-1:0]        max_drive;
		logic [BAND_W-1:0]       settle_band;
		logic signed [POS_W-1:0] target_low;
		logic signed [POS_W-1:0] target_high;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prop_gain:   32'd587203,
		integ_gain:  32'd252,
		deriv_gain:  32'd33554432,
		min_drive:   7'd25,
		max_drive:   7'd100,
		settle_band: 8'd10,
		target_low:  16'h8000,
		target_high: 16'h7FFF
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_LOAD,
		ST_DIV,
		ST_INTEG,
		ST_TOTAL,
		ST_ROUND,
		ST_DONE
	} state_t;

endpackage

>>> hw/rtl/pdrv_regs.sv
// Configuration register file behind the APB-style port.
module pdrv_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pdrv_pkg::ADDR_W-1:0]  paddr,
	input  logic [pdrv_pkg::DATA_W-1:0]  pwdata,
	output logic [pdrv_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output pdrv_pkg::cfg_t               cfg
);

	pdrv_pkg::cfg_t                  cfg_q;
	logic [pdrv_pkg::IDX_W-1:0]      idx;
	logic                            wr_en;

	assign idx    = paddr[pdrv_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= pdrv_pkg::CFG_RESET;
		end else if (wr_en) begin
			case (idx)
				pdrv_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= pwdata;
				pdrv_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain  <= pwdata;
				pdrv_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain  <= pwdata;
				pdrv_pkg::REG_MIN_DRIVE:   cfg_q.min_drive   <= pwdata[pdrv_pkg::LIM_W-1:0];
				pdrv_pkg::REG_MAX_DRIVE:   cfg_q.max_drive   <= pwdata[pdrv_pkg::LIM_W-1:0];
				pdrv_pkg::REG_SETTLE_BAND: cfg_q.settle_band <= pwdata[pdrv_pkg::BAND_W-1:0];
				pdrv_pkg::REG_TARGET_LOW:  cfg_q.target_low  <= pwdata[pdrv_pkg::POS_W-1:0];
				pdrv_pkg::REG_TARGET_HIGH: cfg_q.target_high <= pwdata[pdrv_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			pdrv_pkg::REG_PROP_GAIN:   prdata = cfg_q.prop_gain;
			pdrv_pkg::REG_INTEG_GAIN:  prdata = cfg_q.integ_gain;
			pdrv_pkg::REG_DERIV_GAIN:  prdata = cfg_q.deriv_gain;
			pdrv_pkg::REG_MIN_DRIVE:   prdata = {{(pdrv_pkg::DATA_W-pdrv_pkg::LIM_W){1'b0}},
				cfg_q.min_drive};
			pdrv_pkg::REG_MAX_DRIVE:   prdata = {{(pdrv_pkg::DATA_W-pdrv_pkg::LIM_W){1'b0}},
				cfg_q.max_drive};
			pdrv_pkg::REG_SETTLE_BAND: prdata = {{(pdrv_pkg::DATA_W-pdrv_pkg::BAND_W){1'b0}},
				cfg_q.settle_band};
			pdrv_pkg::REG_TARGET_LOW:  prdata = {{(pdrv_pkg::DATA_W-pdrv_pkg::POS_W){1'b0}},
				cfg_q.target_low};
			pdrv_pkg::REG_TARGET_HIGH: prdata = {{(pdrv_pkg::DATA_W-pdrv_pkg::POS_W){1'b0}},
				cfg_q.target_high};
			default: prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/pdrv_smul.sv
// Bit-serial shift-add multiplier, multiplier bits taken MSB first, optional saturation.
module pdrv_smul #(
	parameter int MW     = 32,
	parameter int BW     = 17,
	parameter int PW     = 49,
	parameter bit SAT_EN = 1'b0
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [MW-1:0] mcand,
	input  logic [BW-1:0] mplier,
	output logic [PW-1:0] product
);

	localparam int SW = PW + 1;

	logic [MW-1:0] mcand_q;
	logic [BW-1:0] bits_q;
	logic [PW-1:0] acc_q;
	logic [SW-1:0] sum;
	logic [PW-1:0] acc_d;

	always_comb begin
		sum   = {acc_q, 1'b0} + (bits_q[BW-1] ? SW'(mcand_q) : '0);
		acc_d = sum[PW-1:0];
		if (SAT_EN && (sum > SW'(pdrv_pkg::INTEG_LIM))) begin
			acc_d = PW'(pdrv_pkg::INTEG_LIM);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mcand_q <= mcand;
			bits_q  <= mplier;
			acc_q   <= '0;
		end else if (step) begin
			acc_q  <= acc_d;
			bits_q <= {bits_q[BW-2:0], 1'b0};
		end
	end

	assign product = acc_q;

endmodule

>>> hw/rtl/pdrv_sdiv.sv
// Restoring divider, one quotient bit per cycle while step is high; a zero divisor counts as one.
module pdrv_sdiv #(
	parameter int NW = 49,
	parameter int DW = 16
) (
	input  logic          clk,
	input  logic          load,
	input  logic          step,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [NW-1:0] quotient
);

	logic [DW-1:0] dvs_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	assign trial = {rem_q, quo_q[NW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (load) begin
			dvs_q <= (divisor == '0) ? DW'(1) : divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (step) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

>>> hw/rtl/pid_position_drive.sv
// Top level of the PID position drive with deadband offset.
//
// Usage: write gains and limits over the APB-style port while no item is in
// flight. Each sample item (target, measured position, interval, start flag)
// is taken on sample_valid & sample_ready; one result item (drive_power,
// settled, position_error) leaves on result_valid & result_ready.
// Processing order from the accepting edge to result_valid: bit-serial P, D
// and I multiplies, a load state, the bit-serial divider for the derivative
// term, then the integral update, the sum, rounding and drive limiting.
// One item at a time; each runs the whole sequence, 49 divider steps included.
// sample_ready is high only while the sequencer is idle.
// The result sits in an output register, so the next item is taken while a
// result waits; if the receiver still stalls when the next result is ready,
// the sequencer holds that result until the register frees up.
// Reset: registers return to their defaults, previous error becomes 10, the
// integral clears and no result is pending.
module pid_position_drive (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [pdrv_pkg::ADDR_W-1:0]        paddr,
	input  logic [pdrv_pkg::DATA_W-1:0]        pwdata,
	output logic [pdrv_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               sample_valid,
	output logic                               sample_ready,
	input  logic signed [pdrv_pkg::POS_W-1:0]  target_position,
	input  logic signed [pdrv_pkg::POS_W-1:0]  measured_position,
	input  logic [pdrv_pkg::TICK_W-1:0]        interval_ticks,
	input  logic                               start_move,
	output logic                               result_valid,
	input  logic                               result_ready,
	output logic signed [pdrv_pkg::DRV_W-1:0]  drive_power,
	output logic                               settled,
	output logic signed [pdrv_pkg::ERR_W-1:0]  position_error
);

	localparam int IRAW_W = pdrv_pkg::INTEG_W + 2;
	localparam logic signed [IRAW_W-1:0] IRAW_MAX =
		{3'b000, {(pdrv_pkg::INTEG_W-1){1'b1}}};
	localparam logic signed [IRAW_W-1:0] IRAW_MIN =
		{3'b111, {(pdrv_pkg::INTEG_W-1){1'b0}}};
	localparam logic [pdrv_pkg::TOTAL_W-1:0] HALF =
		{{(pdrv_pkg::TOTAL_W-pdrv_pkg::FRAC_W){1'b0}}, 1'b1, {(pdrv_pkg::FRAC_W-1){1'b0}}};

	pdrv_pkg::cfg_t   cfg;
	pdrv_pkg::state_t state_q, state_d;
	logic [pdrv_pkg::CNT_W-1:0] cnt_q, cnt_d;

	logic accept, finish, out_free;

	logic signed [pdrv_pkg::POS_W-1:0] tgt_clamp;
	logic signed [pdrv_pkg::ERR_W-1:0] err_new, prev_eff, prev_q;
	logic signed [pdrv_pkg::DLT_W-1:0] dlt_new;
	logic [pdrv_pkg::ERR_W-1:0]        err_abs;
	logic [pdrv_pkg::DLT_W-1:0]        dlt_abs;
	logic [pdrv_pkg::MAG_W-1:0]        err_mag, dlt_mag;
	logic                              settled_new;

	logic signed [pdrv_pkg::ERR_W-1:0] err_q;
	logic                              err_neg_q, dlt_neg_q, settled_q;
	logic [pdrv_pkg::TICK_W-1:0]       ticks_q;

	logic [pdrv_pkg::PROD_W-1:0] p_prod, d_prod, i_prod, t_prod, d_quo;

	logic signed [pdrv_pkg::INTEG_W-1:0] integ_q, integ_new;
	logic signed [IRAW_W-1:0]            integ_raw, integ_ext, integ_inc;
	logic [pdrv_pkg::SUM_W-1:0]          p_term, d_term;
	logic signed [pdrv_pkg::SUM_W-1:0]   sum_new, sum_q;
	logic signed [pdrv_pkg::TOTAL_W-1:0] total_new, total_q;
	logic [pdrv_pkg::TOTAL_W-1:0]        rnd_sum;
	logic [pdrv_pkg::RND_W-1:0]          rnd_q;
	logic                                rnd_neg_q;

	logic [pdrv_pkg::RND_W:0]            drv_sum;
	logic [pdrv_pkg::LIM_W-1:0]          drv_lim;
	logic signed [pdrv_pkg::DRV_W-1:0]   drive_new;

	logic                                result_valid_q, settled_out_q;
	logic signed [pdrv_pkg::DRV_W-1:0]   drive_q;
	logic signed [pdrv_pkg::ERR_W-1:0]   err_out_q;

	pdrv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign sample_ready = (state_q == pdrv_pkg::ST_IDLE);
	assign accept       = sample_valid & sample_ready;
	assign out_free     = ~result_valid_q | result_ready;
	assign finish       = (state_q == pdrv_pkg::ST_DONE) & out_free;

	// error, error change and settled flag of the incoming item
	always_comb begin
		tgt_clamp = target_position;
		if (tgt_clamp > cfg.target_high) begin
			tgt_clamp = cfg.target_high;
		end
		if (tgt_clamp < cfg.target_low) begin
			tgt_clamp = cfg.target_low;
		end
		err_new     = {tgt_clamp[pdrv_pkg::POS_W-1], tgt_clamp}
			- {measured_position[pdrv_pkg::POS_W-1], measured_position};
		prev_eff    = start_move ? pdrv_pkg::PREV_INIT : prev_q;
		dlt_new     = {err_new[pdrv_pkg::ERR_W-1], err_new}
			- {prev_eff[pdrv_pkg::ERR_W-1], prev_eff};
		err_abs     = err_new[pdrv_pkg::ERR_W-1] ? -err_new : err_new;
		dlt_abs     = dlt_new[pdrv_pkg::DLT_W-1] ? -dlt_new : dlt_new;
		err_mag     = err_abs;
		dlt_mag     = dlt_abs[pdrv_pkg::MAG_W-1:0];
		settled_new = (err_abs <= {{(pdrv_pkg::ERR_W-pdrv_pkg::BAND_W){1'b0}},
			cfg.settle_band}) && (err_new == prev_eff);
	end

	pdrv_smul #(
		.MW(pdrv_pkg::GAIN_W), .BW(pdrv_pkg::MAG_W), .PW(pdrv_pkg::PROD_W), .SAT_EN(1'b0)
	) u_pmul (
		.clk(clk), .load(accept), .step(state_q == pdrv_pkg::ST_MUL),
		.mcand(cfg.prop_gain), .mplier(err_mag), .product(p_prod)
	);

	pdrv_smul #(
		.MW(pdrv_pkg::GAIN_W), .BW(pdrv_pkg::MAG_W), .PW(pdrv_pkg::PROD_W), .SAT_EN(1'b0)
	) u_dmul (
		.clk(clk), .load(accept), .step(state_q == pdrv_pkg::ST_MUL),
		.mcand(cfg.deriv_gain), .mplier(dlt_mag), .product(d_prod)
	);

	pdrv_smul #(
		.MW(pdrv_pkg::GAIN_W), .BW(pdrv_pkg::MAG_W), .PW(pdrv_pkg::PROD_W), .SAT_EN(1'b1)
	) u_imul (
		.clk(clk), .load(accept), .step(state_q == pdrv_pkg::ST_MUL),
		.mcand(cfg.integ_gain), .mplier(err_mag), .product(i_prod)
	);

	pdrv_smul #(
		.MW(pdrv_pkg::INTEG_W), .BW(pdrv_pkg::TICK_W), .PW(pdrv_pkg::PROD_W), .SAT_EN(1'b1)
	) u_tmul (
		.clk(clk), .load(state_q == pdrv_pkg::ST_LOAD),
		.step((state_q == pdrv_pkg::ST_DIV) && (cnt_q < pdrv_pkg::CNT_W'(pdrv_pkg::TICK_W))),
		.mcand(i_prod[pdrv_pkg::INTEG_W-1:0]), .mplier(ticks_q), .product(t_prod)
	);

	pdrv_sdiv #(
		.NW(pdrv_pkg::PROD_W), .DW(pdrv_pkg::TICK_W)
	) u_div (
		.clk(clk), .load(state_q == pdrv_pkg::ST_LOAD), .step(state_q == pdrv_pkg::ST_DIV),
		.dividend(d_prod), .divisor(ticks_q), .quotient(d_quo)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			pdrv_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (sample_valid) begin
					state_d = pdrv_pkg::ST_MUL;
				end
			end
			pdrv_pkg::ST_MUL: begin
				if (cnt_q == pdrv_pkg::CNT_W'(pdrv_pkg::MAG_W - 1)) begin
					state_d = pdrv_pkg::ST_LOAD;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			pdrv_pkg::ST_LOAD: begin
				state_d = pdrv_pkg::ST_DIV;
				cnt_d   = '0;
			end
			pdrv_pkg::ST_DIV: begin
				if (cnt_q == pdrv_pkg::CNT_W'(pdrv_pkg::PROD_W - 1)) begin
					state_d = pdrv_pkg::ST_INTEG;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			pdrv_pkg::ST_INTEG: state_d = pdrv_pkg::ST_TOTAL;
			pdrv_pkg::ST_TOTAL: state_d = pdrv_pkg::ST_ROUND;
			pdrv_pkg::ST_ROUND: state_d = pdrv_pkg::ST_DONE;
			pdrv_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = pdrv_pkg::ST_IDLE;
				end
			end
			default: state_d = pdrv_pkg::ST_IDLE;
		endcase
	end

	// integral update, term sum, rounding and drive limiting
	always_comb begin
		integ_ext = {{2{integ_q[pdrv_pkg::INTEG_W-1]}}, integ_q};
		integ_inc = {1'b0, t_prod};
		integ_raw = err_neg_q ? (integ_ext - integ_inc) : (integ_ext + integ_inc);
		if (integ_raw > IRAW_MAX) begin
			integ_new = IRAW_MAX[pdrv_pkg::INTEG_W-1:0];
		end else if (integ_raw < IRAW_MIN) begin
			integ_new = IRAW_MIN[pdrv_pkg::INTEG_W-1:0];
		end else begin
			integ_new = integ_raw[pdrv_pkg::INTEG_W-1:0];
		end

		p_term  = {2'b00, p_prod};
		d_term  = {2'b00, d_quo};
		sum_new = (err_neg_q ? -p_term : p_term) + (dlt_neg_q ? -d_term : d_term);

		total_new = {sum_q[pdrv_pkg::SUM_W-1], sum_q}
			+ {{(pdrv_pkg::TOTAL_W-pdrv_pkg::INTEG_W){integ_q[pdrv_pkg::INTEG_W-1]}}, integ_q};

		rnd_sum = total_q[pdrv_pkg::TOTAL_W-1] ? (~total_q + (HALF + 1'b1)) : (total_q + HALF);

		drv_sum = {1'b0, rnd_q} + {{(pdrv_pkg::RND_W+1-pdrv_pkg::LIM_W){1'b0}}, cfg.min_drive};
		if (rnd_q == '0) begin
			drv_lim = '0;
		end else if (drv_sum > {{(pdrv_pkg::RND_W+1-pdrv_pkg::LIM_W){1'b0}}, cfg.max_drive})
		begin
			drv_lim = cfg.max_drive;
		end else begin
			drv_lim = drv_sum[pdrv_pkg::LIM_W-1:0];
		end
		drive_new = rnd_neg_q ? -{1'b0, drv_lim} : {1'b0, drv_lim};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pdrv_pkg::ST_IDLE;
			cnt_q          <= '0;
			prev_q         <= pdrv_pkg::PREV_INIT;
			integ_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (accept) begin
				prev_q <= err_new;
				if (start_move) begin
					integ_q <= '0;
				end
			end
			if (state_q == pdrv_pkg::ST_INTEG) begin
				integ_q <= integ_new;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_q     <= err_new;
			err_neg_q <= err_new[pdrv_pkg::ERR_W-1];
			dlt_neg_q <= dlt_new[pdrv_pkg::DLT_W-1];
			ticks_q   <= interval_ticks;
			settled_q <= settled_new;
		end
		if (state_q == pdrv_pkg::ST_INTEG) begin
			sum_q <= sum_new;
		end
		if (state_q == pdrv_pkg::ST_TOTAL) begin
			total_q <= total_new;
		end
		if (state_q == pdrv_pkg::ST_ROUND) begin
			rnd_q     <= rnd_sum[pdrv_pkg::TOTAL_W-1:pdrv_pkg::FRAC_W];
			rnd_neg_q <= total_q[pdrv_pkg::TOTAL_W-1];
		end
		if (finish) begin
			drive_q       <= drive_new;
			settled_out_q <= settled_q;
			err_out_q     <= err_q;
		end
	end

	assign result_valid   = result_valid_q;
	assign drive_power    = drive_q;
	assign settled        = settled_out_q;
	assign position_error = err_out_q;

endmodule

>>> hw/rtl/pdrv_checker.sv
// Port-level checks of the PID position drive, bound to the top level.
module pdrv_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               sample_valid,
	input logic                               sample_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input logic signed [pdrv_pkg::DRV_W-1:0]  drive_power,
	input logic                               settled,
	input logic signed [pdrv_pkg::ERR_W-1:0]  position_error
);

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result item dropped while stalled");

	a_payload_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(drive_power) && $stable(settled)
			&& $stable(position_error))
		else $error("result item changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("sample accepted while an item is in flight");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> drive_power != 8'sh80)
		else $error("drive outside symmetric range");

	a_settled_band: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && settled |-> (position_error <= 17'sd255) && (position_error >= -17'sd255))
		else $error("settled with error beyond any band");

endmodule

bind pid_position_drive pdrv_checker u_pdrv_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.sample_valid   (sample_valid),
	.sample_ready   (sample_ready),
	.result_valid   (result_valid),
	.result_ready   (result_ready),
	.drive_power    (drive_power),
	.settled        (settled),
	.position_error (position_error)
);

>>> bench/tb_pid_position_drive.sv
// Testbench for pid_position_drive: checks each drive result against a bit-exact drive predictor.
module tb_pid_position_drive;
	import pdrv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int SEGMENT_ITEMS = 137;
	localparam bit [63:0] TERM_LIM = 64'd1 << 60;

	typedef struct packed {
		logic signed [DRV_W-1:0] drive;
		logic                    settled;
		logic signed [ERR_W-1:0] err;
	} drive_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sample_valid;
	logic sample_ready;
	logic signed [POS_W-1:0] target_position;
	logic signed [POS_W-1:0] measured_position;
	logic [TICK_W-1:0] interval_ticks;
	logic start_move;
	logic result_valid;
	logic result_ready;
	logic signed [DRV_W-1:0] drive_power;
	logic settled;
	logic signed [ERR_W-1:0] position_error;

	cfg_t cfg = CFG_RESET;
	longint last_err = longint'(PREV_INIT);
	longint integ_acc = 0;
	drive_result_t drive_results_due[$];
	int error_count = 0;
	int items_sent = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int unsigned cycle_count = 0;

	pid_position_drive u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.target_position(target_position),
		.measured_position(measured_position),
		.interval_ticks(interval_ticks),
		.start_move(start_move),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.drive_power(drive_power),
		.settled(settled),
		.position_error(position_error)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic bit [63:0] mag_of(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	function automatic longint with_sign(bit [63:0] mag, bit neg);
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic bit [63:0] sat_mul(bit [63:0] a, bit [63:0] b, bit [63:0] lim);
		if (a != 0 && b > lim / a)
			return lim;
		return (a * b > lim) ? lim : a * b;
	endfunction

	function automatic drive_result_t compute_drive(logic signed [POS_W-1:0] tgt_in,
			logic signed [POS_W-1:0] meas, logic [TICK_W-1:0] ticks, logic start);
		longint tgt;
		longint err;
		longint delta;
		longint pterm;
		longint dterm;
		longint total;
		longint drive;
		bit [63:0] mag;
		bit [63:0] div;
		drive_result_t r;
		if (start) begin
			integ_acc = 0;
			last_err = longint'(PREV_INIT);
		end
		tgt = longint'(tgt_in);
		if (tgt > $signed(cfg.target_high))
			tgt = $signed(cfg.target_high);
		if (tgt < $signed(cfg.target_low))
			tgt = $signed(cfg.target_low);
		err = tgt - meas;
		delta = err - last_err;
		pterm = with_sign(sat_mul(cfg.prop_gain, mag_of(err), TERM_LIM), err < 0);
		div = (ticks == 0) ? 64'd1 : 64'(ticks);
		mag = sat_mul(cfg.deriv_gain, mag_of(delta), TERM_LIM) / div;
		dterm = with_sign(mag, delta < 0);
		mag = sat_mul(sat_mul(cfg.integ_gain, mag_of(err), 64'(INTEG_LIM)), 64'(ticks),
			64'(INTEG_LIM));
		integ_acc = integ_acc + with_sign(mag, err < 0);
		if (integ_acc > longint'(INTEG_LIM) - 1)
			integ_acc = longint'(INTEG_LIM) - 1;
		if (integ_acc < -longint'(INTEG_LIM))
			integ_acc = -longint'(INTEG_LIM);
		total = pterm + dterm + integ_acc;
		mag = (mag_of(total) + (64'd1 << (FRAC_W - 1))) >> FRAC_W;
		drive = with_sign(mag, total < 0);
		if (drive >= 1)
			drive = drive + longint'(cfg.min_drive);
		if (drive <= -1)
			drive = drive - longint'(cfg.min_drive);
		if (drive > longint'(cfg.max_drive))
			drive = longint'(cfg.max_drive);
		if (drive < -longint'(cfg.max_drive))
			drive = -longint'(cfg.max_drive);
		r.settled = (mag_of(err) <= 64'(cfg.settle_band)) && (err == last_err);
		last_err = err;
		r.drive = drive[DRV_W-1:0];
		r.err = err[ERR_W-1:0];
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(int v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return 16'sh8000;
		return v[POS_W-1:0];
	endfunction

	function automatic logic [TICK_W-1:0] pick_ticks();
		case ($urandom_range(9))
			0: return '0;
			1: return TICK_W'($urandom());
			2: return '1;
			default: return TICK_W'($urandom_range(1, 400));
		endcase
	endfunction

	function automatic logic [GAIN_W-1:0] pick_gain(bit extreme, int unsigned typical_hi);
		if (extreme)
			return $urandom_range(1) ? '1 : '0;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return $urandom();
			default: return $urandom_range(typical_hi);
		endcase
	endfunction

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PROP_GAIN:   cfg.prop_gain = value;
			REG_INTEG_GAIN:  cfg.integ_gain = value;
			REG_DERIV_GAIN:  cfg.deriv_gain = value;
			REG_MIN_DRIVE:   cfg.min_drive = value[LIM_W-1:0];
			REG_MAX_DRIVE:   cfg.max_drive = value[LIM_W-1:0];
			REG_SETTLE_BAND: cfg.settle_band = value[BAND_W-1:0];
			REG_TARGET_LOW:  cfg.target_low = value[POS_W-1:0];
			REG_TARGET_HIGH: cfg.target_high = value[POS_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_sample(logic signed [POS_W-1:0] tgt, logic signed [POS_W-1:0] meas,
			logic [TICK_W-1:0] ticks, logic start);
		int gap;
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			gap = $urandom_range(1, 150);
			sample_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid <= 1'b1;
		target_position <= tgt;
		measured_position <= meas;
		interval_ticks <= ticks;
		start_move <= start;
		do @(posedge clk); while (!sample_ready);
		drive_results_due.push_back(compute_drive(tgt, meas, ticks, start));
		items_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (drive_results_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(bit extreme);
		int lo;
		int hi;
		wait_drained();
		write_reg(REG_PROP_GAIN, pick_gain(extreme, 32'd1 << 25));
		write_reg(REG_INTEG_GAIN, pick_gain(extreme, 32'd4096));
		write_reg(REG_DERIV_GAIN, pick_gain(extreme, 32'd1 << 27));
		write_reg(REG_MIN_DRIVE, extreme ? ($urandom_range(1) ? 127 : 0) : $urandom_range(40));
		write_reg(REG_MAX_DRIVE, extreme ? ($urandom_range(1) ? 127 : 0) : $urandom_range(127));
		write_reg(REG_SETTLE_BAND, extreme ? ($urandom_range(1) ? 255 : 0) : $urandom_range(255));
		if (extreme) begin
			lo = $urandom_range(1) ? 32767 : -32768;
			hi = $urandom_range(1) ? 32767 : -32768;
		end else begin
			case ($urandom_range(5))
				0: begin
					lo = -32768;
					hi = 32767;
				end
				1: begin
					lo = $urandom_range(3000);
					hi = -int'($urandom_range(3000));
				end
				default: begin
					lo = -int'($urandom_range(32768));
					hi = $urandom_range(32767);
				end
			endcase
		end
		write_reg(REG_TARGET_LOW, 32'(lo));
		write_reg(REG_TARGET_HIGH, 32'(hi));
	endtask

	task automatic test_defaults_and_settle();
		send_sample(16'sd100, 16'sd90, 16'd70, 1'b1);
		send_sample(16'sd100, 16'sd90, 16'd70, 1'b0);
		send_sample(16'sd100, 16'sd95, 16'd5, 1'b0);
		send_sample(16'sd100, 16'sd95, 16'd5, 1'b0);
		send_sample(16'sd100, 16'sd111, 16'd9, 1'b0);
		send_sample(16'sd100, 16'sd111, 16'd9, 1'b0);
	endtask

	task automatic test_field_extremes();
		send_sample(16'sh7FFF, 16'sh8000, 16'd70, 1'b1);
		send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);
		send_sample(16'sd0, 16'sd0, 16'd0, 1'b0);
		send_sample(16'sh7FFF, 16'sh7FFF, 16'd1, 1'b0);
		send_sample(-16'sd1, 16'sd0, 16'h8000, 1'b1);
	endtask

	task automatic test_crossed_limits();
		wait_drained();
		write_reg(REG_TARGET_LOW, 32'd500);
		write_reg(REG_TARGET_HIGH, -32'sd500);
		send_sample(16'sd0, 16'sd0, 16'd70, 1'b1);
		send_sample(16'sh8000, 16'sd0, 16'd10, 1'b0);
		send_sample(16'sh7FFF, 16'sd0, 16'd10, 1'b0);
		wait_drained();
		write_reg(REG_TARGET_LOW, -32'sd200);
		write_reg(REG_TARGET_HIGH, 32'd300);
		send_sample(16'sd1000, 16'sd0, 16'd10, 1'b0);
		send_sample(-16'sd1000, 16'sd0, 16'd10, 1'b0);
	endtask

	task automatic test_drive_limits();
		wait_drained();
		write_reg(REG_MAX_DRIVE, 32'd0);
		write_reg(REG_SETTLE_BAND, 32'd255);
		send_sample(16'sd300, -16'sd200, 16'd20, 1'b1);
		send_sample(-16'sd200, 16'sd300, 16'd20, 1'b0);
		wait_drained();
		write_reg(REG_MAX_DRIVE, 32'd127);
		write_reg(REG_MIN_DRIVE, 32'd127);
		send_sample(16'sd40, 16'sd10, 16'd70, 1'b1);
		send_sample(16'sd10, 16'sd10, 16'd70, 1'b1);
	endtask

	task automatic test_integral_saturation();
		wait_drained();
		write_reg(REG_PROP_GAIN, 32'd0);
		write_reg(REG_DERIV_GAIN, 32'd0);
		write_reg(REG_INTEG_GAIN, 32'hFFFF_FFFF);
		send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b1);
		send_sample(16'sh7FFF, 16'sh8000, 16'hFFFF, 1'b0);
		send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);
		send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);
		send_sample(16'sh8000, 16'sh7FFF, 16'hFFFF, 1'b0);
	endtask

	task automatic run_move();
		int tgt;
		int meas;
		int steps;
		tgt = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 32767 : -32768)
			: int'($urandom_range(65535)) - 32768;
		meas = ($urandom_range(3) == 0) ? int'($urandom_range(65535)) - 32768
			: tgt + int'($urandom_range(4000)) - 2000;
		send_sample(clamp_pos(tgt), clamp_pos(meas),
			($urandom_range(4) == 0) ? pick_ticks() : 16'd70, 1'b1);
		steps = $urandom_range(2, 16);
		repeat (steps) begin
			if ($urandom_range(3) != 0)
				meas = int'(clamp_pos(meas + (tgt - meas) / int'($urandom_range(1, 4))
					+ int'($urandom_range(6)) - 3));
			send_sample(clamp_pos(tgt), clamp_pos(meas), pick_ticks(), 1'b0);
		end
	endtask

	task automatic test_random_phases();
		int stop_at;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 74;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct = 37;
					recv_stall_pct = 37;
				end
			endcase
			for (int setting = 0; setting < 2; setting++) begin
				apply_config(setting == 1 && phase % 2 == 1);
				stop_at = items_sent + SEGMENT_ITEMS;
				while (items_sent < stop_at) begin
					if ($urandom_range(4) == 0)
						send_sample(POS_W'($urandom()), POS_W'($urandom()),
							TICK_W'($urandom()), 1'($urandom()));
					else
						run_move();
				end
			end
		end
	endtask

	initial begin
		int stall_left;
		drive_result_t due;
		stall_left = 0;
		result_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else if ($urandom_range(99) < recv_stall_pct) begin
				stall_left = ($urandom_range(7) == 0) ? $urandom_range(60, 220) : 0;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
			end
			@(posedge clk);
			if (result_valid && result_ready) begin
				if (drive_results_due.size() == 0) begin
					if (error_count < 10)
						$display("unexpected item: drive %0d settled %0d error %0d",
							drive_power, settled, position_error);
					error_count++;
				end else begin
					due = drive_results_due.pop_front();
					if (drive_power !== due.drive || settled !== due.settled
							|| position_error !== due.err) begin
						if (error_count < 10)
							$display("mismatch: drive %0d/%0d settled %0d/%0d error %0d/%0d %s",
								due.drive, drive_power, due.settled, settled,
								due.err, position_error, "(expected/actual)");
						error_count++;
					end
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_valid <= 1'b0;
		target_position <= '0;
		measured_position <= '0;
		interval_ticks <= '0;
		start_move <= 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_defaults_and_settle();
		test_field_extremes();
		test_crossed_limits();
		test_drive_limits();
		test_integral_saturation();
		test_random_phases();
		wait_drained();
		repeat (80) @(posedge clk);
		error_count += drive_results_due.size();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
